@@ rtl/core/u64hm_pkg.sv @@
package u64hm_pkg;

   localparam int KEY_W     = 64;
   localparam int VAL_W     = 32;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 12;

   localparam int BUCKETS_DEFAULT = 256;
   localparam int WAYS_DEFAULT    = 8;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_GET    = 2'd0;
   localparam kind_type KIND_SET    = 2'd1;
   localparam kind_type KIND_REMOVE = 2'd2;
   localparam kind_type KIND_CLEAR  = 2'd3;

   localparam status_type STATUS_HIT       = 3'd0;
   localparam status_type STATUS_INSERTED  = 3'd1;
   localparam status_type STATUS_NOT_FOUND = 3'd2;
   localparam status_type STATUS_FULL      = 3'd3;
   localparam status_type STATUS_CLEARED   = 3'd4;

endpackage

@@ rtl/core/u64hm_fold.sv @@
module u64hm_fold #(
   parameter int BUCKETS = u64hm_pkg::BUCKETS_DEFAULT,
   parameter int BKT_W   = 8
) (
   input  logic [u64hm_pkg::KEY_W-1:0] key,
   output logic [BKT_W-1:0]            bucket
);
   import u64hm_pkg::*;

   localparam int NCH   = (KEY_W + BKT_W - 1) / BKT_W;
   localparam int PAD_W = NCH * BKT_W;

   logic [PAD_W-1:0] padded;
   logic [BKT_W-1:0] folded;

   // xor the key down in bucket-index sized chunks, then one reduce step
   always_comb begin
      padded = PAD_W'(key);
      folded = '0;
      for (int c = 0; c < NCH; c++) begin
         folded = folded ^ padded[c*BKT_W +: BKT_W];
      end
      if ({1'b0, folded} >= (BKT_W+1)'(BUCKETS)) begin
         bucket = BKT_W'({1'b0, folded} - (BKT_W+1)'(BUCKETS));
      end else begin
         bucket = folded;
      end
   end

endmodule

@@ rtl/core/uint64_key_hash_map.sv @@
// Key-value table, 64-bit keys and 32-bit signed values, BUCKETS buckets of WAYS entries.
// A command word is taken when start is high and busy is low; every command (get, set,
// remove, clear) gives exactly one response word, registered at the end of the compare
// step and strobed by rsp_valid for one cycle. The response cannot be stalled. A read
// step fetches the bucket row from the single-port row memory; a compare step checks all
// ways, writes the row back on a set or a hitting remove and registers the response.
// busy is high during the compare step, so a new command is not taken until it is over.
// Clear goes through the same steps: bucket fills are kept valid by one flip-flop per
// bucket, so no clearing pass is needed and the table is ready right after reset.
module uint64_key_hash_map #(
   parameter int BUCKETS = u64hm_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = u64hm_pkg::WAYS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [u64hm_pkg::KIND_W-1:0]        req_kind,
   input  logic [u64hm_pkg::KEY_W-1:0]         req_key,
   input  logic signed [u64hm_pkg::VAL_W-1:0]  req_new_value,
   output logic                                rsp_valid,
   output logic [u64hm_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [u64hm_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [u64hm_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import u64hm_pkg::*;

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int CNT_W  = $clog2(BUCKETS * WAYS + 1);
   localparam int VOFF   = FILL_W + WAYS * KEY_W;
   localparam int ROW_W  = VOFF + WAYS * VAL_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOOK = 1'b1;

   // control
   logic              state_ff, state_in;
   logic [BUCKETS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]  total_ff, total_in;

   // captured command
   kind_type          kind_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  nval_ff;
   logic [BKT_W-1:0]  bkt_ff;

   // row memory: {values, keys, fill} per bucket
   logic [ROW_W-1:0]  mem_ff [BUCKETS];
   logic [ROW_W-1:0]  rd_row_ff;
   logic              rd_valid_ff;
   logic [ROW_W-1:0]  wr_row;
   logic              wr_en;

   // response
   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic [VAL_W-1:0]  rval_ff, rval_in;

   logic              accept;
   logic [BKT_W-1:0]  bkt;

   logic [FILL_W-1:0] fill, fill_new;
   logic [KEY_W-1:0]  keys [WAYS];
   logic [VAL_W-1:0]  vals [WAYS];
   logic              hit_any;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  last_way;
   logic [31:0]       cnt_ext;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff == ST_LOOK);

   u64hm_fold #(
      .BUCKETS(BUCKETS),
      .BKT_W  (BKT_W)
   ) u_fold (
      .key   (req_key),
      .bucket(bkt)
   );

   // bucket row read, issued with the command
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff   <= mem_ff[bkt];
         rd_valid_ff <= valid_ff[bkt];
         kind_ff     <= req_kind;
         key_ff      <= req_key;
         nval_ff     <= req_new_value;
         bkt_ff      <= bkt;
      end
   end

   // write back of the modified row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[bkt_ff] <= wr_row;
      end
   end

   // compare all ways, then update the row
   always_comb begin
      fill = rd_valid_ff ? rd_row_ff[FILL_W-1:0] : '0;
      for (int w = 0; w < WAYS; w++) begin
         keys[w] = rd_row_ff[FILL_W + w*KEY_W +: KEY_W];
         vals[w] = rd_row_ff[VOFF + w*VAL_W +: VAL_W];
      end

      // first matching live way
      hit_any = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if ((FILL_W'(w) < fill) && (keys[w] == key_ff)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      last_way = WAY_W'(fill - FILL_W'(1));

      fill_new  = fill;
      total_in  = total_ff;
      valid_in  = valid_ff;
      status_in = STATUS_NOT_FOUND;
      rval_in   = '0;
      wr_en     = 1'b0;
      state_in  = state_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_IDLE;
            case (kind_ff)
               KIND_GET: begin
                  if (hit_any) begin
                     status_in = STATUS_HIT;
                     rval_in   = vals[hit_way];
                  end
               end
               KIND_SET: begin
                  wr_en = 1'b1;
                  if (hit_any) begin
                     vals[hit_way] = nval_ff;
                     status_in     = STATUS_HIT;
                  end else if (fill < FILL_W'(WAYS)) begin
                     keys[WAY_W'(fill)] = key_ff;
                     vals[WAY_W'(fill)] = nval_ff;
                     fill_new  = fill + FILL_W'(1);
                     total_in  = total_ff + CNT_W'(1);
                     status_in = STATUS_INSERTED;
                  end else begin
                     status_in = STATUS_FULL;
                  end
                  valid_in[bkt_ff] = 1'b1;
               end
               KIND_REMOVE: begin
                  if (hit_any) begin
                     wr_en = 1'b1;
                     keys[hit_way] = keys[last_way];
                     vals[hit_way] = vals[last_way];
                     fill_new  = fill - FILL_W'(1);
                     total_in  = total_ff - CNT_W'(1);
                     status_in = STATUS_HIT;
                     valid_in[bkt_ff] = 1'b1;
                  end
               end
               default: begin
                  // clear: drop every fill at once
                  valid_in  = '0;
                  total_in  = '0;
                  status_in = STATUS_CLEARED;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      wr_row[FILL_W-1:0] = fill_new;
      for (int w = 0; w < WAYS; w++) begin
         wr_row[FILL_W + w*KEY_W +: KEY_W] = keys[w];
         wr_row[VOFF + w*VAL_W +: VAL_W]   = vals[w];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= (state_ff == ST_LOOK);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         status_ff <= status_in;
         rval_ff   <= rval_in;
      end
   end

   assign cnt_ext         = 32'(total_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_value  = rval_ff;
   assign rsp_entry_count = cnt_ext[COUNT_W-1:0];

   // busy is followed in the next cycle by idle and by the one response word
   a_look_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("lookup did not finish in one cycle");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start a lookup");

   a_rsp_only_after_look: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response word without a lookup");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(BUCKETS * WAYS))
      else $error("entry count above capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy)
      else $error("row write outside a lookup");

endmodule
